FILE: rtl/grc_pkg.sv
// Shared types, constants and the sine table for the grid raycast column renderer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package grc_pkg;

	localparam int MAP_SIZE   = 16;
	localparam int MAX_ROWS   = 64;
	localparam int ANGLE_BITS = 12;
	// cells in Q4.12 after the >>16 of an 80x scaled position are 5 units wide
	localparam int CELL_LIMIT = MAP_SIZE * 5;

	localparam int DIV_NW = 22;
	localparam int DIV_DW = 11;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_FOV    = 2'd2;
	localparam logic [1:0] CFG_DEPTH  = 2'd3;

	localparam logic OP_MAP_WRITE = 1'b0;
	localparam logic OP_CAST      = 1'b1;

	// character codes
	localparam logic [3:0] CH_BLANK = 4'd0;
	localparam logic [3:0] CH_WALL1 = 4'd1;
	localparam logic [3:0] CH_WALL2 = 4'd2;
	localparam logic [3:0] CH_WALL3 = 4'd3;
	localparam logic [3:0] CH_WALL4 = 4'd4;
	localparam logic [3:0] CH_HASH  = 4'd5;
	localparam logic [3:0] CH_CROSS = 4'd6;
	localparam logic [3:0] CH_DOT   = 4'd7;
	localparam logic [3:0] CH_DASH  = 4'd8;

	typedef enum logic [3:0] {
		F_IDLE,
		F_ADIV,
		F_AWAIT,
		F_SIN,
		F_COS,
		F_MINIT,
		F_MARCH,
		F_CORNER,
		F_EDGE,
		F_CDIV,
		F_CWAIT,
		F_PUSH
	} front_state_t;

	// one finished column, handed from the caster to the row emitter
	typedef struct packed {
		logic [7:0]         col;
		logic [6:0]         height;
		logic signed [11:0] ceil_row;
		logic signed [11:0] floor_row;
		logic [3:0]         shade;
	} job_t;

	function automatic logic [14:0] quarter_sine(input logic [5:0] idx);
		case (idx)
			6'd0:  quarter_sine = 15'd0;
			6'd1:  quarter_sine = 15'd804;
			6'd2:  quarter_sine = 15'd1606;
			6'd3:  quarter_sine = 15'd2404;
			6'd4:  quarter_sine = 15'd3196;
			6'd5:  quarter_sine = 15'd3981;
			6'd6:  quarter_sine = 15'd4756;
			6'd7:  quarter_sine = 15'd5520;
			6'd8:  quarter_sine = 15'd6270;
			6'd9:  quarter_sine = 15'd7005;
			6'd10: quarter_sine = 15'd7723;
			6'd11: quarter_sine = 15'd8423;
			6'd12: quarter_sine = 15'd9102;
			6'd13: quarter_sine = 15'd9760;
			6'd14: quarter_sine = 15'd10394;
			6'd15: quarter_sine = 15'd11003;
			6'd16: quarter_sine = 15'd11585;
			6'd17: quarter_sine = 15'd12140;
			6'd18: quarter_sine = 15'd12665;
			6'd19: quarter_sine = 15'd13160;
			6'd20: quarter_sine = 15'd13623;
			6'd21: quarter_sine = 15'd14053;
			6'd22: quarter_sine = 15'd14449;
			6'd23: quarter_sine = 15'd14811;
			6'd24: quarter_sine = 15'd15137;
			6'd25: quarter_sine = 15'd15426;
			6'd26: quarter_sine = 15'd15679;
			6'd27: quarter_sine = 15'd15893;
			6'd28: quarter_sine = 15'd16069;
			6'd29: quarter_sine = 15'd16207;
			6'd30: quarter_sine = 15'd16305;
			6'd31: quarter_sine = 15'd16364;
			default: quarter_sine = 15'd16384;
		endcase
	endfunction

	// Q1.14 sine of a 16-bit phase, quarter table with truncated interpolation
	function automatic logic signed [15:0] sine_of_phase(input logic [15:0] p);
		logic [14:0] u;
		logic [5:0]  i;
		logic [8:0]  fr;
		logic [14:0] t0;
		logic [14:0] t1;
		logic [9:0]  dlt;
		logic [18:0] prod;
		logic [14:0] m;
		u    = p[14] ? (15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
		i    = u[14:9];
		fr   = u[8:0];
		t0   = quarter_sine(i);
		t1   = quarter_sine(i + 6'd1);
		dlt  = 10'(t1 - t0);
		prod = 19'(dlt) * 19'(fr);
		if (i[5])
			m = 15'd16384;
		else
			m = t0 + 15'(prod[18:9]);
		sine_of_phase = p[15] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

endpackage

FILE: rtl/grid_raycast_column_renderer.sv
// Grid raycaster column renderer: top level with configuration registers.
// Depends on grc_pkg, grc_front, grc_fifo and grc_back.
//
// Use: requests arrive on s_axis; tuser is the opcode. A map write (opcode 0)
// stores one 16-bit wall row and yields nothing.
// A cast (opcode 1) marches one ray and then streams screen_height characters
// on m_axis, row 0 first, tlast on the final row.
// Steps of a cast: setup (angle division, sine, cosine), march steps (up to
// 10*max_depth) until the ray hits a wall, leaves the map or reaches the depth,
// corner checks and an edge test on a wall hit, the ceiling division on the
// shared divider, and queueing of the column. Rows then leave at one per cycle
// while m_axis_tready is high.
// A two-column queue sits between the caster and the row emitter, so the caster
// takes the next request while the previous column is still being emitted. When
// the receiver stalls, the current row holds and the queue fills; the caster
// then waits with its result and s_axis_tready stays low. Reset clears the wall
// map and loads the default configuration (width 120, height 40, fov 512, depth
// 16). Write configuration only while idle; the block does not enforce this.
`timescale 1ns / 1ps

module grid_raycast_column_renderer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [11:0] cfg_data,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // map_row, row_bits, player_x, player_y,
	                                   // player_angle, column
	input  logic        s_axis_tuser,  // opcode
	// character stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_column, out_row, char_code, zero pad
	output logic        m_axis_tlast
);

	// configuration registers
	logic [7:0]  width_q;
	logic [6:0]  height_q;
	logic [11:0] fov_q;
	logic [4:0]  depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd120;
			height_q <= 7'd40;
			fov_q    <= 12'd512;
			depth_q  <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_addr)
				grc_pkg::CFG_WIDTH:  width_q  <= cfg_data[7:0];
				grc_pkg::CFG_HEIGHT: height_q <= cfg_data[6:0];
				grc_pkg::CFG_FOV:    fov_q    <= cfg_data;
				grc_pkg::CFG_DEPTH:  depth_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	grc_pkg::job_t front_job, head_job;
	logic          job_push, job_full, job_pop, job_empty;
	logic [7:0]    o_col;
	logic [5:0]    o_row;
	logic [3:0]    o_code;

	grc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_opcode       (s_axis_tuser),
		.in_map_row      (s_axis_tdata[3:0]),
		.in_row_bits     (s_axis_tdata[19:4]),
		.in_player_x     (s_axis_tdata[35:20]),
		.in_player_y     (s_axis_tdata[51:36]),
		.in_player_angle (s_axis_tdata[63:52]),
		.in_column       (s_axis_tdata[71:64]),
		.cfg_width       (width_q),
		.cfg_height      (height_q),
		.cfg_fov         (fov_q),
		.cfg_depth       (depth_q),
		.job             (front_job),
		.job_push        (job_push),
		.job_full        (job_full)
	);

	grc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (front_job),
		.full     (job_full),
		.pop      (job_pop),
		.head     (head_job),
		.empty    (job_empty)
	);

	grc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_ready  (!job_empty),
		.job_in     (head_job),
		.job_pop    (job_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_column (o_col),
		.out_row    (o_row),
		.char_code  (o_code),
		.last       (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, o_code, o_row, o_col};

`ifndef NO_ASSERTIONS
	// the caster never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("column queue overflow");

	// rows of a column follow one another without gaps
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tdata[13:8] == $past(m_axis_tdata[13:8]) + 6'd1))
		else $error("row sequence broken");

	// a new column always starts at row zero
	a_col_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
		(!m_axis_tvalid || m_axis_tdata[13:8] == 6'd0))
		else $error("column did not restart at row zero");
`endif

endmodule

FILE: rtl/grc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the angle and ceiling maths.
// Depends on grc_pkg for its widths.
`timescale 1ns / 1ps

module grc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [grc_pkg::DIV_NW-1:0]   num,
	input  logic [grc_pkg::DIV_DW-1:0]   den,
	output logic                         done,
	output logic [grc_pkg::DIV_NW-1:0]   quot
);

	logic [grc_pkg::DIV_DW-1:0] rem_q;
	logic [grc_pkg::DIV_DW-1:0] den_q;
	logic [grc_pkg::DIV_NW-1:0] quo_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [grc_pkg::DIV_DW:0]   trial;
	logic                       fits;

	assign trial = {rem_q, quo_q[grc_pkg::DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 5'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(grc_pkg::DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? grc_pkg::DIV_DW'(trial - {1'b0, den_q})
			              : trial[grc_pkg::DIV_DW-1:0];
			quo_q <= {quo_q[grc_pkg::DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: rtl/grc_front.sv
// Caster: takes input requests, keeps the wall map, marches one ray and finds the
// ceiling, floor and shade of the column. Depends on grc_pkg and grc_div.
`timescale 1ns / 1ps

module grc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_opcode,
	input  logic [3:0]       in_map_row,
	input  logic [15:0]      in_row_bits,
	input  logic [15:0]      in_player_x,
	input  logic [15:0]      in_player_y,
	input  logic [11:0]      in_player_angle,
	input  logic [7:0]       in_column,
	input  logic [7:0]       cfg_width,
	input  logic [6:0]       cfg_height,
	input  logic [11:0]      cfg_fov,
	input  logic [4:0]       cfg_depth,
	output grc_pkg::job_t    job,
	output logic             job_push,
	input  logic             job_full
);

	grc_pkg::front_state_t state_q, state_d;

	logic [15:0] wall_q [grc_pkg::MAP_SIZE];

	logic [15:0]        px_q, py_q;
	logic [11:0]        pang_q, fov_q, ang_q;
	logic [7:0]         col_q;
	logic [6:0]         h_q;
	logic [8:0]         wden_q;
	logic [21:0]        anum_q;
	logic [9:0]         d20_q, dn_q;
	logic signed [15:0] ex_q, ey_q;
	logic signed [25:0] ax_q, ay_q;
	logic [3:0]         cx_q, cy_q;
	logic [1:0]         ci_q, cj_q, ph_q;
	logic signed [37:0] p1_q, p2_q;
	logic signed [38:0] dist_q, dot_q;
	logic signed [38:0] b0d_q, b1d_q, b0t_q, b1t_q, b0c_q, b1c_q;
	logic               b0v_q, b1v_q, edge_q, neg_q;
	logic signed [11:0] ceil_q, floor_q;
	logic [3:0]         shade_q;

	// divider
	logic        div_start, div_done;
	logic [21:0] div_num, div_quot;
	logic [10:0] div_den;

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// accept-time values
	logic [7:0]  w_eff;
	logic [6:0]  h_eff;
	logic [21:0] anum;
	assign w_eff = (cfg_width == 8'd0) ? 8'd1 : cfg_width;
	always_comb begin
		if (cfg_height == 7'd0)
			h_eff = 7'd1;
		else if (cfg_height > 7'(grc_pkg::MAX_ROWS))
			h_eff = 7'(grc_pkg::MAX_ROWS);
		else
			h_eff = cfg_height;
	end
	assign anum = 22'(cfg_fov) * 22'({1'b0, in_column, 1'b0} + {2'b0, w_eff});

	// march step
	logic signed [25:0] axn, ayn;
	logic [8:0]         tx, ty;
	logic [16:0]        mx, my;
	logic [3:0]         cxn, cyn;
	logic               off_map, is_wall;
	assign axn = ax_q + {{9{ex_q[15]}}, ex_q, 1'b0};
	assign ayn = ay_q + {{9{ey_q[15]}}, ey_q, 1'b0};
	assign tx  = axn[24:16];
	assign ty  = ayn[24:16];
	assign mx  = 17'(tx) * 17'd205;
	assign my  = 17'(ty) * 17'd205;
	assign cxn = mx[13:10];
	assign cyn = my[13:10];
	assign off_map = axn[25] || ayn[25] || (tx >= 9'(grc_pkg::CELL_LIMIT))
	                 || (ty >= 9'(grc_pkg::CELL_LIMIT));
	assign is_wall = wall_q[cyn][cxn];

	// corner vectors
	logic [4:0]         cxi, cyj;
	logic signed [18:0] vx, vy;
	logic signed [38:0] cdiff, cabs;
	assign cxi = 5'(cx_q) + 5'(ci_q);
	assign cyj = 5'(cy_q) + 5'(cj_q);
	assign vx  = $signed({2'b0, cxi, 12'b0}) - $signed({3'b0, px_q});
	assign vy  = $signed({2'b0, cyj, 12'b0}) - $signed({3'b0, py_q});
	assign cdiff = 39'(p1_q) - 39'(p2_q);
	assign cabs  = cdiff[38] ? -cdiff : cdiff;

	logic b0_take, b1_take;
	assign b0_take = !b0v_q || (dist_q < b0d_q);
	assign b1_take = !b1v_q || (dist_q < b1d_q);

	// edge test
	logic signed [45:0] c0x100, c1x100;
	logic               e0, e1;
	assign c0x100 = {{7{b0c_q[38]}}, b0c_q} * 46'sd100;
	assign c1x100 = {{7{b1c_q[38]}}, b1c_q} * 46'sd100;
	assign e0 = b0v_q && (b0t_q > 39'sd0) && (c0x100 < {{7{b0t_q[38]}}, b0t_q});
	assign e1 = b1v_q && (b1t_q > 39'sd0) && (c1x100 < {{7{b1t_q[38]}}, b1t_q});

	// ceiling numerator
	logic [9:0]  dn_off;
	logic [16:0] cnum;
	assign dn_off = (dn_q < 10'd40) ? (10'd40 - dn_q) : (dn_q - 10'd40);
	assign cnum   = 17'(h_q) * 17'(dn_off);

	// shade
	logic [11:0] dn4, dn3, dn2, d20w;
	logic [3:0]  shade_d;
	assign dn4  = {dn_q, 2'b0};
	assign dn3  = 12'(dn_q) * 12'd3;
	assign dn2  = {1'b0, dn_q, 1'b0};
	assign d20w = 12'(d20_q);
	always_comb begin
		if (dn4 <= d20w)
			shade_d = grc_pkg::CH_WALL1;
		else if (dn3 < d20w)
			shade_d = grc_pkg::CH_WALL2;
		else if (dn2 < d20w)
			shade_d = grc_pkg::CH_WALL3;
		else if (dn_q < d20_q)
			shade_d = grc_pkg::CH_WALL4;
		else
			shade_d = grc_pkg::CH_BLANK;
		if (edge_q && dn_q < d20_q)
			shade_d = grc_pkg::CH_BLANK;
	end

	logic signed [11:0] ceil_d;
	assign ceil_d = neg_q ? -$signed({1'b0, div_quot[10:0]}) : $signed({1'b0, div_quot[10:0]});

	logic corner_last;
	assign corner_last = (ph_q == 2'd3) && (ci_q == 2'd2) && (cj_q == 2'd2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			grc_pkg::F_IDLE:  if (in_valid && in_opcode == grc_pkg::OP_CAST)
				state_d = grc_pkg::F_ADIV;
			grc_pkg::F_ADIV:  state_d = grc_pkg::F_AWAIT;
			grc_pkg::F_AWAIT: if (div_done) state_d = grc_pkg::F_SIN;
			grc_pkg::F_SIN:   state_d = grc_pkg::F_COS;
			grc_pkg::F_COS:   state_d = grc_pkg::F_MINIT;
			grc_pkg::F_MINIT: state_d = grc_pkg::F_MARCH;
			grc_pkg::F_MARCH: begin
				if (!(dn_q < d20_q) || off_map)
					state_d = grc_pkg::F_CDIV;
				else if (is_wall)
					state_d = grc_pkg::F_CORNER;
			end
			grc_pkg::F_CORNER: if (corner_last) state_d = grc_pkg::F_EDGE;
			grc_pkg::F_EDGE:   state_d = grc_pkg::F_CDIV;
			grc_pkg::F_CDIV:   state_d = grc_pkg::F_CWAIT;
			grc_pkg::F_CWAIT:  if (div_done) state_d = grc_pkg::F_PUSH;
			grc_pkg::F_PUSH:   if (!job_full) state_d = grc_pkg::F_IDLE;
			default:           state_d = grc_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == grc_pkg::F_IDLE);
		div_start = (state_q == grc_pkg::F_ADIV) || (state_q == grc_pkg::F_CDIV);
		div_num   = (state_q == grc_pkg::F_CDIV) ? 22'(cnum) : anum_q;
		div_den   = (state_q == grc_pkg::F_CDIV) ? {dn_q, 1'b0} : {2'b0, wden_q};
		job_push  = (state_q == grc_pkg::F_PUSH) && !job_full;
	end

	assign job = '{col: col_q, height: h_q, ceil_row: ceil_q, floor_row: floor_q,
	               shade: shade_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grc_pkg::F_IDLE;
			for (int r = 0; r < grc_pkg::MAP_SIZE; r++)
				wall_q[r] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == grc_pkg::F_IDLE && in_valid
			    && in_opcode == grc_pkg::OP_MAP_WRITE)
				wall_q[in_map_row] <= in_row_bits;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			grc_pkg::F_IDLE: begin
				px_q   <= in_player_x;
				py_q   <= in_player_y;
				pang_q <= in_player_angle;
				col_q  <= in_column;
				fov_q  <= cfg_fov;
				h_q    <= h_eff;
				wden_q <= {w_eff, 1'b0};
				anum_q <= anum;
				d20_q  <= 10'(cfg_depth) * 10'd20;
			end
			grc_pkg::F_AWAIT: ang_q <= pang_q + div_quot[11:0] - fov_q;
			grc_pkg::F_SIN:   ex_q <= grc_pkg::sine_of_phase({ang_q, 4'b0});
			grc_pkg::F_COS:   ey_q <= grc_pkg::sine_of_phase({ang_q, 4'b0} + 16'h4000);
			grc_pkg::F_MINIT: begin
				ax_q   <= $signed({3'b0, 23'(px_q) * 23'd80}) + 26'(ex_q);
				ay_q   <= $signed({3'b0, 23'(py_q) * 23'd80}) + 26'(ey_q);
				dn_q   <= 10'd1;
				edge_q <= 1'b0;
				b0v_q  <= 1'b0;
				b1v_q  <= 1'b0;
				ci_q   <= '0;
				cj_q   <= '0;
				ph_q   <= '0;
			end
			grc_pkg::F_MARCH: begin
				if (dn_q < d20_q) begin
					ax_q <= axn;
					ay_q <= ayn;
					cx_q <= cxn;
					cy_q <= cyn;
					dn_q <= off_map ? d20_q : dn_q + 10'd2;
				end
			end
			grc_pkg::F_CORNER: begin
				ph_q <= ph_q + 2'd1;
				case (ph_q)
					2'd0: begin
						p1_q <= vx * vx;
						p2_q <= vy * vy;
					end
					2'd1: begin
						dist_q <= 39'(p1_q) + 39'(p2_q);
						p1_q   <= 38'(ex_q * vx);
						p2_q   <= 38'(ey_q * vy);
					end
					2'd2: begin
						dot_q <= 39'(p1_q) + 39'(p2_q);
						p1_q  <= 38'(ex_q * vy);
						p2_q  <= 38'(ey_q * vx);
					end
					default: begin
						if (b0_take) begin
							b1d_q <= b0d_q;
							b1t_q <= b0t_q;
							b1c_q <= b0c_q;
							b1v_q <= b0v_q;
							b0d_q <= dist_q;
							b0t_q <= dot_q;
							b0c_q <= cabs;
							b0v_q <= 1'b1;
						end else if (b1_take) begin
							b1d_q <= dist_q;
							b1t_q <= dot_q;
							b1c_q <= cabs;
							b1v_q <= 1'b1;
						end
						if (cj_q == 2'd2) begin
							cj_q <= '0;
							ci_q <= ci_q + 2'd1;
						end else begin
							cj_q <= cj_q + 2'd1;
						end
					end
				endcase
			end
			grc_pkg::F_EDGE: edge_q <= e0 || e1;
			grc_pkg::F_CDIV: neg_q <= dn_q < 10'd40;
			grc_pkg::F_CWAIT: begin
				ceil_q  <= ceil_d;
				floor_q <= $signed({5'b0, h_q}) - ceil_d;
				shade_q <= shade_d;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/grc_fifo.sv
// Two-entry queue of finished columns between the caster and the row emitter.
// Depends on grc_pkg for the job type.
`timescale 1ns / 1ps

module grc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  grc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output grc_pkg::job_t head,
	output logic          empty
);

	grc_pkg::job_t mem_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

endmodule

FILE: rtl/grc_back.sv
// Row emitter: walks one finished column and produces a character per screen row.
// Depends on grc_pkg for the job type and character codes.
`timescale 1ns / 1ps

module grc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_ready,
	input  grc_pkg::job_t job_in,
	output logic          job_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_column,
	output logic [5:0]    out_row,
	output logic [3:0]    char_code,
	output logic          last
);

	grc_pkg::job_t job_q;
	logic          active_q;
	logic [5:0]    y_q;

	logic signed [11:0] ys;
	logic [6:0]         r;
	logic [10:0]        r8, r4, r20, hw, h3, h9;

	assign ys  = $signed({6'b0, y_q});
	assign r   = job_q.height - {1'b0, y_q};
	assign r8  = {1'b0, r, 3'b0};
	assign r4  = {2'b0, r, 2'b0};
	assign r20 = 11'(r) * 11'd20;
	assign hw  = 11'(job_q.height);
	assign h3  = 11'(job_q.height) * 11'd3;
	assign h9  = 11'(job_q.height) * 11'd9;

	always_comb begin
		if (ys <= job_q.ceil_row)
			char_code = grc_pkg::CH_BLANK;
		else if (ys <= job_q.floor_row)
			char_code = job_q.shade;
		else if (r8 < hw)
			char_code = grc_pkg::CH_HASH;
		else if (r4 < hw)
			char_code = grc_pkg::CH_CROSS;
		else if (r8 < h3)
			char_code = grc_pkg::CH_DOT;
		else if (r20 < h9)
			char_code = grc_pkg::CH_DASH;
		else
			char_code = grc_pkg::CH_BLANK;
	end

	assign last       = {1'b0, y_q} == (job_q.height - 7'd1);
	assign out_valid  = active_q;
	assign out_column = job_q.col;
	assign out_row    = y_q;
	assign job_pop    = !active_q && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			y_q      <= '0;
		end else if (job_pop) begin
			active_q <= 1'b1;
			y_q      <= '0;
		end else if (active_q && out_ready) begin
			if (last)
				active_q <= 1'b0;
			else
				y_q <= y_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job_in;
	end

endmodule
